FILE: rtl/core/fea_pkg.sv
// Shared types and constants for the free extent allocator.
// No dependencies.
package fea_pkg;
	localparam int MaxExtents = 16;
	localparam int IdxW = $clog2(MaxExtents);
	localparam int CntW = $clog2(MaxExtents + 1);

	localparam logic [2:0] KindAllocAny  = 3'd0;
	localparam logic [2:0] KindAllocAt   = 3'd1;
	localparam logic [2:0] KindFree      = 3'd2;
	localparam logic [2:0] KindProbeBack = 3'd3;
	localparam logic [2:0] KindProbeFwd  = 3'd4;
	localparam logic [2:0] KindReinit    = 3'd5;

	localparam logic [1:0] StOk      = 2'd0;
	localparam logic [1:0] StNoFit   = 2'd1;
	localparam logic [1:0] StFull    = 2'd2;
	localparam logic [1:0] StNotFree = 2'd3;

	localparam logic CfgQuantum = 1'b0;
	localparam logic CfgRegion  = 1'b1;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
	} extent_t;

	// Row operation applied by every cell in the same cycle.
	typedef enum logic [2:0] {
		OpHold  = 3'd0,
		OpWrite = 3'd1, // cell at sel takes wr value
		OpDrop  = 3'd2, // cells at sel and above take right neighbor
		OpIns   = 3'd3, // cells above sel take left neighbor, sel takes wr
		OpInit  = 3'd4  // cell 0 takes wr
	} row_op_t;

	typedef struct packed {
		row_op_t       op;
		logic [IdxW-1:0] sel;
		extent_t       wr;
	} row_ctl_t;
endpackage

FILE: rtl/core/fea_cell.sv
// One extent cell of the sorted row; shifts to either neighbor.
// Depends on fea_pkg.
module fea_cell (
	input  logic                 clk,
	input  logic [fea_pkg::IdxW-1:0] idx,
	input  fea_pkg::row_ctl_t    ctl,
	input  fea_pkg::extent_t     left,
	input  fea_pkg::extent_t     right,
	output fea_pkg::extent_t     cur
);
	fea_pkg::extent_t ext_q;
	assign cur = ext_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			fea_pkg::OpWrite: if (idx == ctl.sel) ext_q <= ctl.wr;
			fea_pkg::OpDrop:  if (idx >= ctl.sel) ext_q <= right;
			fea_pkg::OpIns: begin
				if (idx == ctl.sel) ext_q <= ctl.wr;
				else if (idx > ctl.sel) ext_q <= left;
			end
			fea_pkg::OpInit:  if (idx == '0) ext_q <= ctl.wr;
			default: ;
		endcase
	end
endmodule

FILE: rtl/core/free_extent_allocator.sv
// Top level of the free extent allocator: sequencer over a row of extent cells.
// Depends on fea_pkg and fea_cell.
//
// Usage: drive kind, start_req, size, take_best, at_least with start high
// while busy is low; the request is taken at that edge and busy rises.
// The sequencer then scans the cell row one cell per cycle, then in S_DEC
// computes the decision and updates the row in the same cycle (a split or a
// free joining both neighbors adds a second row write on entry to S_SUM),
// then rescans the row for total and largest and registers the result in
// S_OUT. The result appears for one cycle with done high; busy falls with
// it. One request at a time.
// The receiver cannot stall: done is shown once and does not wait for it.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 quantum_log2,
// 1 region_size) and cfg_data; cfg_ready is always high, writes are
// meant only while busy is low.
// Reset clears the extent count, both registers and the sequencer; cell
// contents are undefined until written, only cells below the count are read.
module free_extent_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [31:0] start_req,
	input  logic [31:0] size,
	input  logic        take_best,
	input  logic [31:0] at_least,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] grant_start,
	output logic [31:0] grant_size,
	output logic [31:0] total_free,
	output logic [31:0] largest_free,
	output logic [4:0]  extent_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int N = fea_pkg::MaxExtents;
	localparam int IW = fea_pkg::IdxW;
	localparam int CW = fea_pkg::CntW;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_DEC  = 5'b00100,
		S_SUM  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [4:0]  qlog_q;
	logic [31:0] region_q;
	logic [CW-1:0] used_q;
	logic [2:0]  kind_q;
	logic [31:0] st_q, sz_q;
	logic        tb_q;
	logic [CW-1:0] ptr_q;
	// scan results
	logic          ff_hit_q;  logic [IW-1:0] ff_idx_q;
	logic          bst_hit_q; logic [IW-1:0] bst_idx_q; logic [31:0] thr_q;
	logic          at_hit_q;  logic [IW-1:0] at_idx_q;
	logic [CW-1:0] pos_q;     logic pos_set_q;
	logic          pb_hit_q;  logic [31:0] pb_sz_q;
	logic [1:0]    status_q;
	logic [31:0]   gs_q, gz_q, tot_q, big_q;
	// second write for the split case and the double coalesce
	logic fix_q; logic [IW-1:0] fix_idx_q; fea_pkg::extent_t fix_ext_q;

	fea_pkg::row_ctl_t ctl;
	fea_pkg::extent_t  cells [N];
	fea_pkg::extent_t  zero_ext;
	assign zero_ext = '0;

	for (genvar g = 0; g < N; g++) begin : g_row
		fea_cell u_cell (
			.clk  (clk),
			.idx  (IW'(g)),
			.ctl  (ctl),
			.left ((g == 0) ? zero_ext : cells[(g == 0) ? 0 : g - 1]),
			.right((g == N - 1) ? zero_ext : cells[(g == N - 1) ? g : g + 1]),
			.cur  (cells[g])
		);
	end

	assign cfg_ready = 1'b1;
	assign busy = (state_q != S_IDLE);

	fea_pkg::extent_t sc;
	logic [32:0] sc_end;
	logic [32:0] rend;
	logic [IW-1:0] pidx;
	assign pidx = ptr_q[IW-1:0];
	assign sc = cells[pidx];
	assign sc_end = {1'b0, sc.start} + {1'b0, sc.size};
	assign rend = {1'b0, st_q} + {1'b0, sz_q};

	// decision inputs
	fea_pkg::extent_t ef, eb, ea, ep, eq;
	logic [32:0] ea_end, ep_end;
	logic [31:0] qm;
	logic [32:0] need;
	logic [IW-1:0] pm1, p0;
	assign ef = cells[ff_idx_q];
	assign eb = cells[bst_idx_q];
	assign ea = cells[at_idx_q];
	assign pm1 = IW'(pos_q - CW'(1));
	assign p0 = pos_q[IW-1:0];
	assign ep = cells[pm1];
	assign eq = cells[p0];
	assign ea_end = {1'b0, ea.start} + {1'b0, ea.size};
	assign ep_end = {1'b0, ep.start} + {1'b0, ep.size};
	assign qm = (32'd1 << qlog_q) - 32'd1;
	assign need = {1'b0, sz_q} + {1'b0, qm};

	logic [1:0] d_status; logic [31:0] d_gs, d_gz;
	logic [CW-1:0] d_used;
	logic lj, rj, full;
	assign full = (used_q >= CW'(N));
	assign lj = (pos_q != '0) && (ep_end == {1'b0, st_q});
	assign rj = (pos_q < used_q) && (rend == {1'b0, eq.start});

	always_comb begin
		ctl = '0;
		ctl.op = fea_pkg::OpHold;
		d_status = fea_pkg::StOk; d_gs = '0; d_gz = '0; d_used = used_q;
		case (kind_q)
			fea_pkg::KindAllocAny: begin
				if (ff_hit_q) begin
					d_gs = ef.start;
					if ({1'b0, ef.size} <= need) begin
						d_gz = ef.size;
						ctl.op = fea_pkg::OpDrop; ctl.sel = ff_idx_q;
						d_used = used_q - CW'(1);
					end else begin
						d_gz = need[31:0] & ~qm;
						ctl.op = fea_pkg::OpWrite; ctl.sel = ff_idx_q;
						ctl.wr.start = ef.start + d_gz;
						ctl.wr.size = ef.size - d_gz;
					end
				end else if (bst_hit_q) begin
					d_gs = eb.start; d_gz = eb.size;
					ctl.op = fea_pkg::OpDrop; ctl.sel = bst_idx_q;
					d_used = used_q - CW'(1);
				end else d_status = fea_pkg::StNoFit;
			end
			fea_pkg::KindAllocAt: begin
				if (sz_q != '0) begin
					if (!at_hit_q || ea.start > st_q || ea_end < rend)
						d_status = fea_pkg::StNotFree;
					else if (ea.start == st_q) begin
						ctl.sel = at_idx_q;
						if (ea.size == sz_q) begin
							ctl.op = fea_pkg::OpDrop; d_used = used_q - CW'(1);
						end else begin
							ctl.op = fea_pkg::OpWrite;
							ctl.wr.start = ea.start + sz_q;
							ctl.wr.size = ea.size - sz_q;
						end
					end else if (ea_end == rend) begin
						ctl.op = fea_pkg::OpWrite; ctl.sel = at_idx_q;
						ctl.wr.start = ea.start; ctl.wr.size = ea.size - sz_q;
					end else if (full) d_status = fea_pkg::StFull;
					else begin
						// split: tail inserted above, head trimmed in S_SUM entry
						ctl.op = fea_pkg::OpIns; ctl.sel = at_idx_q + IW'(1);
						ctl.wr.start = rend[31:0];
						ctl.wr.size = ea_end[31:0] - rend[31:0];
						d_used = used_q + CW'(1);
					end
				end
				if (d_status == fea_pkg::StOk) begin d_gs = st_q; d_gz = sz_q; end
			end
			fea_pkg::KindFree: begin
				if (sz_q != '0) begin
					if (rend > 33'h0FFFFFFFF) d_status = fea_pkg::StNotFree;
					else if ((pos_q != '0 && ep_end > {1'b0, st_q}) ||
					         (pos_q < used_q && rend > {1'b0, eq.start}))
						d_status = fea_pkg::StNotFree;
					else if (lj && rj) begin
						ctl.op = fea_pkg::OpDrop; ctl.sel = p0;
						d_used = used_q - CW'(1);
					end else if (lj) begin
						ctl.op = fea_pkg::OpWrite; ctl.sel = pm1;
						ctl.wr.start = ep.start; ctl.wr.size = ep.size + sz_q;
					end else if (rj) begin
						ctl.op = fea_pkg::OpWrite; ctl.sel = p0;
						ctl.wr.start = st_q; ctl.wr.size = eq.size + sz_q;
					end else if (full) d_status = fea_pkg::StFull;
					else begin
						ctl.op = fea_pkg::OpIns; ctl.sel = p0;
						ctl.wr.start = st_q; ctl.wr.size = sz_q;
						d_used = used_q + CW'(1);
					end
				end
			end
			fea_pkg::KindProbeBack, fea_pkg::KindProbeFwd: begin
				if (pb_hit_q) d_gz = pb_sz_q;
			end
			fea_pkg::KindReinit: begin
				d_used = (region_q != '0) ? CW'(1) : '0;
				ctl.op = fea_pkg::OpInit; ctl.wr.start = '0; ctl.wr.size = region_q;
			end
			default: ;
		endcase
		if (state_q != S_DEC) ctl.op = fea_pkg::OpHold;
		if (state_q == S_SUM && fix_q) begin
			ctl.op = fea_pkg::OpWrite; ctl.sel = fix_idx_q; ctl.wr = fix_ext_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; qlog_q <= '0; region_q <= '0; used_q <= '0;
			done <= 1'b0; fix_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == fea_pkg::CfgQuantum) qlog_q <= cfg_data[4:0];
				else region_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: if (start) begin
					kind_q <= kind; st_q <= start_req; sz_q <= size;
					tb_q <= take_best;
					ptr_q <= '0; ff_hit_q <= 1'b0; bst_hit_q <= 1'b0;
					thr_q <= at_least - 32'd1; at_hit_q <= 1'b0;
					pos_q <= '0; pos_set_q <= 1'b0; pb_hit_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (ptr_q >= used_q) state_q <= S_DEC;
					else begin
						if (!ff_hit_q && sc.size >= sz_q) begin
							ff_hit_q <= 1'b1; ff_idx_q <= pidx;
						end
						if (tb_q && sc.size > thr_q) begin
							thr_q <= sc.size; bst_hit_q <= 1'b1; bst_idx_q <= pidx;
						end
						if (!at_hit_q && sc_end >= {1'b0, st_q}) begin
							at_hit_q <= 1'b1; at_idx_q <= pidx;
						end
						if (!pos_set_q) begin
							if (sc.start <= st_q) pos_q <= ptr_q + CW'(1);
							else pos_set_q <= 1'b1;
						end
						if (!pb_hit_q && ((kind_q == fea_pkg::KindProbeBack &&
						    sc_end == {1'b0, st_q}) ||
						    (kind_q == fea_pkg::KindProbeFwd && sc.start == st_q))) begin
							pb_hit_q <= 1'b1; pb_sz_q <= sc.size;
						end
						ptr_q <= ptr_q + CW'(1);
					end
				end
				S_DEC: begin
					status_q <= d_status; gs_q <= d_gs; gz_q <= d_gz;
					used_q <= d_used;
					fix_q <= 1'b0;
					if (kind_q == fea_pkg::KindAllocAt && ctl.op == fea_pkg::OpIns) begin
						fix_q <= 1'b1; fix_idx_q <= at_idx_q;
						fix_ext_q.start <= ea.start;
						fix_ext_q.size <= st_q - ea.start;
					end
					if (kind_q == fea_pkg::KindFree && ctl.op == fea_pkg::OpDrop) begin
						fix_q <= 1'b1; fix_idx_q <= pm1;
						fix_ext_q.start <= ep.start;
						fix_ext_q.size <= ep.size + sz_q + eq.size;
					end
					ptr_q <= '0; tot_q <= '0; big_q <= '0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					fix_q <= 1'b0;
					if (!fix_q) begin
						if (ptr_q >= used_q) state_q <= S_OUT;
						else begin
							tot_q <= tot_q + sc.size;
							if (sc.size > big_q) big_q <= sc.size;
							ptr_q <= ptr_q + CW'(1);
						end
					end
				end
				S_OUT: begin
					done <= 1'b1;
					status <= status_q; grant_start <= gs_q; grant_size <= gz_q;
					total_free <= tot_q; largest_free <= big_q;
					extent_count <= 5'(used_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: tb/sv/free_extent_allocator_tb.sv
// Self-checking testbench for free_extent_allocator: a queue-fed request
// driver, a result monitor and an extent-table predictor in SystemVerilog.
// Depends on fea_pkg and the free_extent_allocator RTL.
module free_extent_allocator_tb;
	typedef struct {
		logic [2:0]  kind;
		logic [31:0] start_req;
		logic [31:0] size;
		logic        take_best;
		logic [31:0] at_least;
		bit          is_cfg;
		bit          cfg_idx;
		logic [31:0] cfg_val;
	} req_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] grant_start;
		logic [31:0] grant_size;
		logic [31:0] total_free;
		logic [31:0] largest_free;
		logic [4:0]  extent_count;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] kind = '0;
	logic [31:0] start_req = '0, size = '0, at_least = '0;
	logic take_best = 1'b0;
	logic done;
	logic [1:0] status;
	logic [31:0] grant_start, grant_size, total_free, largest_free;
	logic [4:0] extent_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	free_extent_allocator dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [31:0] tbl_start [fea_pkg::MaxExtents];
	logic [31:0] tbl_size [fea_pkg::MaxExtents];
	int unsigned used;
	logic [4:0] q_log2;
	logic [31:0] region;

	req_t pending[$];
	rsp_t expected[$];
	int errors = 0;
	int stall = 0;
	int idle_cnt = 0;
	bit quiet = 0;
	int calm = 0;

	function automatic void drop_at(int unsigned i);
		for (int unsigned k = i; k + 1 < used; k++) begin
			tbl_start[k] = tbl_start[k+1];
			tbl_size[k] = tbl_size[k+1];
		end
		if (used > 0) used--;
	endfunction

	function automatic void add_at(int unsigned i, logic [31:0] s, logic [31:0] z);
		for (int unsigned k = used; k > i; k--) begin
			tbl_start[k] = tbl_start[k-1];
			tbl_size[k] = tbl_size[k-1];
		end
		tbl_start[i] = s;
		tbl_size[i] = z;
		used++;
	endfunction

	function automatic logic [32:0] end_at(int unsigned i);
		return {1'b0, tbl_start[i]} + {1'b0, tbl_size[i]};
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int unsigned i, n, pos, best;
		logic [31:0] qm, thr, tail;
		logic [32:0] need, rend;
		bit found, lj, rj;
		o = '{default: '0};
		n = used;
		case (r.kind)
			fea_pkg::KindAllocAny: begin
				qm = (32'd1 << q_log2) - 32'd1;
				for (i = 0; i < n && tbl_size[i] < r.size; i++) ;
				if (i < n) begin
					need = {1'b0, r.size} + {1'b0, qm};
					o.grant_start = tbl_start[i];
					if ({1'b0, tbl_size[i]} <= need) begin
						o.grant_size = tbl_size[i];
						drop_at(i);
					end else begin
						o.grant_size = need[31:0] & ~qm;
						tbl_start[i] += o.grant_size;
						tbl_size[i] -= o.grant_size;
					end
				end else begin
					found = 0;
					best = 0;
					thr = r.at_least - 32'd1;
					if (r.take_best)
						for (i = 0; i < n; i++)
							if (tbl_size[i] > thr) begin
								thr = tbl_size[i];
								best = i;
								found = 1;
							end
					if (found) begin
						o.grant_start = tbl_start[best];
						o.grant_size = tbl_size[best];
						drop_at(best);
					end else o.status = fea_pkg::StNoFit;
				end
			end
			fea_pkg::KindAllocAt: begin
				if (r.size != 0) begin
					rend = {1'b0, r.start_req} + {1'b0, r.size};
					for (i = 0; i < n && end_at(i) < {1'b0, r.start_req}; i++) ;
					if (i >= n || tbl_start[i] > r.start_req || end_at(i) < rend)
						o.status = fea_pkg::StNotFree;
					else if (tbl_start[i] == r.start_req) begin
						if (tbl_size[i] == r.size) drop_at(i);
						else begin
							tbl_start[i] += r.size;
							tbl_size[i] -= r.size;
						end
					end else if (end_at(i) == rend) tbl_size[i] -= r.size;
					else if (n >= fea_pkg::MaxExtents) o.status = fea_pkg::StFull;
					else begin
						tail = 32'(end_at(i) - rend);
						tbl_size[i] = r.start_req - tbl_start[i];
						add_at(i + 1, rend[31:0], tail);
					end
				end
				if (o.status == fea_pkg::StOk) begin
					o.grant_start = r.start_req;
					o.grant_size = r.size;
				end
			end
			fea_pkg::KindFree: begin
				rend = {1'b0, r.start_req} + {1'b0, r.size};
				if (r.size != 0) begin
					if (rend > 33'hFFFFFFFF) o.status = fea_pkg::StNotFree;
					else begin
						for (pos = 0; pos < n && tbl_start[pos] <= r.start_req; pos++) ;
						if ((pos > 0 && end_at(pos-1) > {1'b0, r.start_req}) ||
								(pos < n && rend > {1'b0, tbl_start[pos]}))
							o.status = fea_pkg::StNotFree;
						else begin
							lj = pos > 0 && end_at(pos-1) == {1'b0, r.start_req};
							rj = pos < n && rend == {1'b0, tbl_start[pos]};
							if (lj && rj) begin
								tbl_size[pos-1] += r.size + tbl_size[pos];
								drop_at(pos);
							end else if (lj) tbl_size[pos-1] += r.size;
							else if (rj) begin
								tbl_start[pos] = r.start_req;
								tbl_size[pos] += r.size;
							end else if (n >= fea_pkg::MaxExtents) o.status = fea_pkg::StFull;
							else add_at(pos, r.start_req, r.size);
						end
					end
				end
			end
			fea_pkg::KindProbeBack: begin
				for (i = 0; i < n; i++)
					if (end_at(i) == {1'b0, r.start_req}) begin
						o.grant_size = tbl_size[i];
						break;
					end
			end
			fea_pkg::KindProbeFwd: begin
				for (i = 0; i < n; i++)
					if (tbl_start[i] == r.start_req) begin
						o.grant_size = tbl_size[i];
						break;
					end
			end
			fea_pkg::KindReinit: begin
				used = 0;
				if (region != 0) add_at(0, 32'd0, region);
			end
			default: ;
		endcase
		for (i = 0; i < used; i++) begin
			o.total_free += tbl_size[i];
			if (tbl_size[i] > o.largest_free) o.largest_free = tbl_size[i];
		end
		o.extent_count = 5'(used);
		return o;
	endfunction

	function automatic req_t mk(logic [2:0] k, logic [31:0] s, logic [31:0] z,
			logic t = 0, logic [31:0] a = 0);
		req_t r;
		r = '{default: '0};
		r.kind = k;
		r.start_req = s;
		r.size = z;
		r.take_best = t;
		r.at_least = a;
		return r;
	endfunction

	function automatic req_t mk_cfg(bit idx, logic [31:0] v);
		req_t r;
		r = '{default: '0};
		r.is_cfg = 1;
		r.cfg_idx = idx;
		r.cfg_val = v;
		return r;
	endfunction

	function automatic logic [31:0] rnd32();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 64);
			1: return $urandom_range(0, 4096);
			2: return 32'hFFFFFFFF - $urandom_range(0, 64);
			default: return $urandom;
		endcase
	endfunction

	// well-formed requests mostly, with starts kept inside the region
	function automatic req_t random_req();
		req_t r;
		logic [31:0] base;
		r = mk(3'($urandom_range(0, 5)), rnd32(), rnd32(), 1'($urandom_range(0, 1)),
			rnd32());
		if ($urandom_range(0, 9) == 0) r.kind = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 9) < 7) begin
			base = $urandom_range(0, 60000);
			if (region != 0) base = base % region;
			r.start_req = base;
			r.size = $urandom_range(0, 3000);
			r.at_least = $urandom_range(0, 2000);
			if (r.kind == fea_pkg::KindReinit && $urandom_range(0, 3) != 0)
				r.kind = fea_pkg::KindFree;
		end
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) start <= 1'b0;
			if (cfg_valid && cfg_ready) cfg_valid <= 1'b0;
			if (stall > 0) stall <= stall - 1;
			else if (!(start && !busy) && !start && !cfg_valid && pending.size() > 0) begin
				if (pending[0].is_cfg) begin
					if (expected.size() == 0 && !busy && calm >= 40) begin
						cfg_valid <= 1'b1;
						cfg_index <= pending[0].cfg_idx;
						cfg_data <= pending[0].cfg_val;
						if (pending[0].cfg_idx == fea_pkg::CfgQuantum)
							q_log2 = pending[0].cfg_val[4:0];
						else region = pending[0].cfg_val;
						void'(pending.pop_front());
					end
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					stall <= $urandom_range(1, 6);
				end else begin
					start <= 1'b1;
					kind <= pending[0].kind;
					start_req <= pending[0].start_req;
					size <= pending[0].size;
					take_best <= pending[0].take_best;
					at_least <= pending[0].at_least;
				end
			end
			if (start && !busy) begin
				expected.push_back(apply_request(pending.pop_front()));
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			calm <= (busy || start) ? 0 : calm + 1;
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cnt <= 0;
			else idle_cnt <= idle_cnt + 1;
			if (done) begin
				if (expected.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					e = expected.pop_front();
					if (status !== e.status) begin
						$error("status exp %0d got %0d", e.status, status); errors++;
					end
					if (grant_start !== e.grant_start) begin
						$error("grant_start exp %h got %h", e.grant_start, grant_start);
						errors++;
					end
					if (grant_size !== e.grant_size) begin
						$error("grant_size exp %h got %h", e.grant_size, grant_size); errors++;
					end
					if (total_free !== e.total_free) begin
						$error("total_free exp %h got %h", e.total_free, total_free); errors++;
					end
					if (largest_free !== e.largest_free) begin
						$error("largest_free exp %h got %h", e.largest_free, largest_free);
						errors++;
					end
					if (extent_count !== e.extent_count) begin
						$error("extent_count exp %0d got %0d", e.extent_count, extent_count);
						errors++;
					end
				end
			end
			if (idle_cnt > 5000) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		used = 0;
		q_log2 = 0;
		region = 0;
		// directed
		pending.push_back(mk(fea_pkg::KindAllocAny, 0, 0));
		pending.push_back(mk(fea_pkg::KindReinit, 0, 0));
		pending.push_back(mk(3'd6, 0, 0));
		pending.push_back(mk(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'hFFFFFFFF));
		pending.push_back(mk_cfg(fea_pkg::CfgRegion, 32'hFFFFFFFF));
		pending.push_back(mk_cfg(fea_pkg::CfgQuantum, 4));
		pending.push_back(mk(fea_pkg::KindReinit, 0, 0));
		pending.push_back(mk(fea_pkg::KindAllocAny, 0, 0));
		pending.push_back(mk(fea_pkg::KindAllocAny, 0, 17));
		pending.push_back(mk(fea_pkg::KindAllocAt, 100, 50));
		pending.push_back(mk(fea_pkg::KindAllocAt, 100, 50));
		pending.push_back(mk(fea_pkg::KindAllocAt, 0, 0));
		pending.push_back(mk(fea_pkg::KindProbeBack, 100, 0));
		pending.push_back(mk(fea_pkg::KindProbeFwd, 150, 0));
		pending.push_back(mk(fea_pkg::KindFree, 32'hFFFFFFF0, 32'h20));
		pending.push_back(mk(fea_pkg::KindFree, 120, 10));
		pending.push_back(mk(fea_pkg::KindFree, 100, 20));
		pending.push_back(mk(fea_pkg::KindFree, 130, 20));
		pending.push_back(mk(fea_pkg::KindAllocAny, 0, 32'hFFFFFFFF, 1, 1));
		pending.push_back(mk(fea_pkg::KindAllocAny, 0, 32'hFFFFFFFF, 1, 0));
		pending.push_back(mk(fea_pkg::KindAllocAny, 0, 32'hFFFFFFFF, 0, 1));
		for (int k = 0; k < 17; k++)
			pending.push_back(mk(fea_pkg::KindAllocAt, 1000 + k * 20, 5));
		pending.push_back(mk(fea_pkg::KindFree, 1002, 1));
		pending.push_back(mk_cfg(fea_pkg::CfgQuantum, 31));
		pending.push_back(mk(fea_pkg::KindAllocAny, 0, 3));
		pending.push_back(mk_cfg(fea_pkg::CfgQuantum, 0));
		pending.push_back(mk_cfg(fea_pkg::CfgRegion, 0));
		pending.push_back(mk(fea_pkg::KindReinit, 0, 0));
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// random phases: new registers and reinit, then random requests
		for (int ph = 0; ph < 5; ph++) begin
			wait (pending.size() == 0);
			pending.push_back(mk_cfg(fea_pkg::CfgQuantum,
				ph == 0 ? 16 : $urandom_range(0, 31)));
			pending.push_back(mk_cfg(fea_pkg::CfgRegion, ph == 1 ? 32'hFFFFFFFF : rnd32()));
			pending.push_back(mk(fea_pkg::KindReinit, 0, 0));
			wait (pending.size() == 0);
			if (ph == 4) quiet = 1;
			for (int k = 0; k < 110; k++) pending.push_back(random_req());
		end
		wait (pending.size() == 0 && expected.size() == 0);
		repeat (80) @(posedge clk);
		if (errors == 0 && expected.size() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
